/* hw/rtl/via_pkg.sv */
// Shared types and constants for the versatile interface adapter.
package via_pkg;

   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_CA1   = 3'd3;
   localparam logic [2:0] MODE_CB1   = 3'd4;
   localparam logic [2:0] MODE_CA2   = 3'd5;
   localparam logic [2:0] MODE_CB2   = 3'd6;

   localparam logic [3:0] REG_ORB  = 4'd0;
   localparam logic [3:0] REG_ORA  = 4'd1;
   localparam logic [3:0] REG_DDRB = 4'd2;
   localparam logic [3:0] REG_DDRA = 4'd3;
   localparam logic [3:0] REG_T1CL = 4'd4;
   localparam logic [3:0] REG_T1CH = 4'd5;
   localparam logic [3:0] REG_T1LL = 4'd6;
   localparam logic [3:0] REG_T1LH = 4'd7;
   localparam logic [3:0] REG_T2CL = 4'd8;
   localparam logic [3:0] REG_T2CH = 4'd9;
   localparam logic [3:0] REG_SR   = 4'd10;
   localparam logic [3:0] REG_ACR  = 4'd11;
   localparam logic [3:0] REG_PCR  = 4'd12;
   localparam logic [3:0] REG_IFR  = 4'd13;
   localparam logic [3:0] REG_IER  = 4'd14;
   localparam logic [3:0] REG_ORAN = 4'd15;

   localparam logic [7:0] F_CA2 = 8'h01;
   localparam logic [7:0] F_CA1 = 8'h02;
   localparam logic [7:0] F_CB2 = 8'h08;
   localparam logic [7:0] F_CB1 = 8'h10;
   localparam logic [7:0] F_T2  = 8'h20;
   localparam logic [7:0] F_T1  = 8'h40;

   localparam logic [16:0] TIMER_RESET = 17'h1fffe;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic [6:0] elapsed;
      logic       pin_level;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_drive;
      logic       port_a_strobe;
      logic [7:0] port_b_drive;
      logic       port_b_strobe;
      logic       irq_level;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture item, apply all but timer-1 wrap
      logic wrap;     // one timer-1 reload add
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_wrap; // t1 count still below -3
   } sts_type;

endpackage

/* hw/rtl/versatile_interface_adapter.sv */
// Top level of the 6522-style versatile interface adapter.
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | req_data (via_pkg::req_type)
//   rsp     | out | rsp_valid/rsp_ready | rsp_data (via_pkg::rsp_type)
// Each item is loaded, then gets one timer-1 reload add per wrap step while the
// timer-1 count is below -3, then waits for rsp_ready; the timer-1 wrap adder
// sets how many wrap steps an item needs.
// One item is handled at a time; req_ready is low until the result is taken.
// Synchronous active-high reset returns all registers to their 6522 defaults.
module versatile_interface_adapter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  via_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output via_pkg::rsp_type  rsp_data
);

   via_pkg::cmd_type cmd;
   via_pkg::sts_type sts;

   via_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   via_dp u_dp (
      .clock(clock), .reset(reset),
      .req(req_data), .cmd(cmd), .sts(sts), .rsp(rsp_data)
   );

endmodule

/* hw/rtl/via_ctrl.sv */
// Controller: sequences item load, timer-1 wrap steps and result delivery.
module via_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output via_pkg::cmd_type  cmd,
   input  via_pkg::sts_type  sts
);

   typedef enum logic [1:0] {ST_IDLE, ST_WRAP, ST_DONE} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (sts.need_wrap) begin
               cmd.wrap = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_wrap_only_in_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.wrap |-> state_ff == ST_WRAP) else $error("wrap outside wrap state");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_WRAP) else $error("load did not start work");

endmodule

/* hw/rtl/via_dp.sv */
// Datapath: register file, ports, timers and flag logic.
module via_dp (
   input  logic              clock,
   input  logic              reset,
   input  via_pkg::req_type  req,
   input  via_pkg::cmd_type  cmd,
   output via_pkg::sts_type  sts,
   output via_pkg::rsp_type  rsp
);

   logic [7:0]  out_a_ff, out_b_ff, latch_a_ff, latch_b_ff, dir_a_ff, dir_b_ff;
   logic [7:0]  sr_ff, acr_ff, pcr_ff;
   logic [6:0]  flag_ff, ier_ff;
   logic [16:0] t1_rel_ff, t2_rel_ff;
   logic [18:0] t1_cnt_ff, t2_cnt_ff;
   logic        t1_done_ff, t2_done_ff;
   logic [1:0]  fired_ff;
   logic        ca1_ff, ca2_ff, cb1_ff, cb2_ff;
   logic [7:0]  rd_ff;
   logic        sa_ff, sb_ff;

   logic [7:0]  out_a_in, out_b_in, latch_a_in, latch_b_in, dir_a_in, dir_b_in;
   logic [7:0]  sr_in, acr_in, pcr_in;
   logic [6:0]  flag_in, ier_in;
   logic [16:0] t1_rel_in, t2_rel_in;
   logic [18:0] t1_cnt_in, t2_cnt_in;
   logic        t1_done_in, t2_done_in;
   logic [1:0]  fired_in;
   logic        ca1_in, ca2_in, cb1_in, cb2_in;
   logic [7:0]  rd_in;
   logic        sa_in, sb_in;

   logic signed [18:0] n1, n2, t1c, t2c;
   logic [18:0] t1p1, t2p1;
   logic [7:0]  pa_val, pb_val;
   logic        lvl;

   localparam logic signed [18:0] M2 = -19'sd2;
   localparam logic signed [18:0] M3 = -19'sd3;

   always_comb begin
      out_a_in = out_a_ff; out_b_in = out_b_ff;
      latch_a_in = latch_a_ff; latch_b_in = latch_b_ff;
      dir_a_in = dir_a_ff; dir_b_in = dir_b_ff;
      sr_in = sr_ff; acr_in = acr_ff; pcr_in = pcr_ff;
      flag_in = flag_ff; ier_in = ier_ff;
      t1_rel_in = t1_rel_ff; t2_rel_in = t2_rel_ff;
      t1_cnt_in = t1_cnt_ff; t2_cnt_in = t2_cnt_ff;
      t1_done_in = t1_done_ff; t2_done_in = t2_done_ff;
      fired_in = fired_ff;
      ca1_in = ca1_ff; ca2_in = ca2_ff; cb1_in = cb1_ff; cb2_in = cb2_ff;
      rd_in = rd_ff; sa_in = sa_ff; sb_in = sb_ff;
      lvl = req.pin_level;
      t1c = t1_cnt_ff;
      t2c = t2_cnt_ff;
      n1 = t1c - 19'(req.elapsed);
      n2 = t2c - 19'(req.elapsed);
      t1p1 = 19'(t1_cnt_ff) + 19'd1;
      t2p1 = 19'(t2_cnt_ff) + 19'd1;
      pa_val = (out_a_ff & dir_a_ff) | ((acr_ff[0] ? latch_a_ff : req.port_a_pins) & ~dir_a_ff);
      pb_val = (out_b_ff & dir_b_ff) | ((acr_ff[1] ? latch_b_ff : req.port_b_pins) & ~dir_b_ff);

      if (cmd.wrap) begin
         t1_cnt_in = t1_cnt_ff + 19'(t1_rel_ff) + 19'd4;
      end

      if (cmd.load) begin
         rd_in = '0; sa_in = 1'b0; sb_in = 1'b0;
         case (req.mode)
            via_pkg::MODE_TICK: begin
               fired_in = '0;
               if (n1 < M2 && t1c > M3) begin
                  if (!t1_done_ff) begin
                     flag_in = flag_in | via_pkg::F_T1[6:0];
                     if (n1 == M3) fired_in[0] = 1'b1;
                     out_b_in = out_b_ff ^ {acr_ff[7], 7'd0};
                  end
                  if (!acr_ff[6]) t1_done_in = 1'b1;
               end
               // reload adds run one per cycle in the wrap state
               t1_cnt_in = n1;
               if (!acr_ff[5]) begin
                  t2_cnt_in = n2;
                  if (n2 < M2) begin
                     if (!t2_done_ff) begin
                        flag_in = flag_in | via_pkg::F_T2[6:0];
                        if (n2 == M3) fired_in[1] = 1'b1;
                        t2_done_in = 1'b1;
                     end
                     t2_cnt_in = n2 + 19'h20000;
                  end
               end
            end
            via_pkg::MODE_READ: begin
               case (req.reg_addr)
                  via_pkg::REG_ORA: begin
                     flag_in = flag_in & ~via_pkg::F_CA1[6:0];
                     if ((pcr_ff & 8'h0a) != 8'h02) flag_in = flag_in & ~via_pkg::F_CA2[6:0];
                     rd_in = pa_val;
                  end
                  via_pkg::REG_ORAN: rd_in = pa_val;
                  via_pkg::REG_ORB: begin
                     flag_in = flag_in & ~via_pkg::F_CB1[6:0];
                     if ((pcr_ff & 8'ha0) != 8'h20) flag_in = flag_in & ~via_pkg::F_CB2[6:0];
                     rd_in = pb_val;
                  end
                  via_pkg::REG_DDRA: rd_in = dir_a_ff;
                  via_pkg::REG_DDRB: rd_in = dir_b_ff;
                  via_pkg::REG_T1LL: rd_in = t1_rel_ff[8:1];
                  via_pkg::REG_T1LH: rd_in = t1_rel_ff[16:9];
                  via_pkg::REG_T1CL: begin
                     if (!fired_ff[0]) flag_in = flag_in & ~via_pkg::F_T1[6:0];
                     rd_in = t1p1[8:1];
                  end
                  via_pkg::REG_T1CH: rd_in = t1p1[16:9];
                  via_pkg::REG_T2CL: begin
                     if (!fired_ff[1]) flag_in = flag_in & ~via_pkg::F_T2[6:0];
                     rd_in = t2p1[8:1];
                  end
                  via_pkg::REG_T2CH: rd_in = t2p1[16:9];
                  via_pkg::REG_SR:   rd_in = sr_ff;
                  via_pkg::REG_ACR:  rd_in = acr_ff;
                  via_pkg::REG_PCR:  rd_in = pcr_ff;
                  via_pkg::REG_IER:  rd_in = {1'b1, ier_ff};
                  default: rd_in = {|(flag_ff & ier_ff), flag_ff};
               endcase
            end
            via_pkg::MODE_WRITE: begin
               case (req.reg_addr)
                  via_pkg::REG_ORA: begin
                     flag_in = flag_in & ~via_pkg::F_CA1[6:0];
                     if ((pcr_ff & 8'h0a) != 8'h02) flag_in = flag_in & ~via_pkg::F_CA2[6:0];
                     out_a_in = req.write_data; sa_in = 1'b1;
                  end
                  via_pkg::REG_ORAN: begin
                     out_a_in = req.write_data; sa_in = 1'b1;
                  end
                  via_pkg::REG_ORB: begin
                     flag_in = flag_in & ~via_pkg::F_CB1[6:0];
                     if ((pcr_ff & 8'ha0) != 8'h20) flag_in = flag_in & ~via_pkg::F_CB2[6:0];
                     out_b_in = req.write_data; sb_in = 1'b1;
                  end
                  via_pkg::REG_DDRA: begin dir_a_in = req.write_data; sa_in = 1'b1; end
                  via_pkg::REG_DDRB: begin dir_b_in = req.write_data; sb_in = 1'b1; end
                  via_pkg::REG_ACR:  acr_in = req.write_data;
                  via_pkg::REG_PCR:  pcr_in = req.write_data;
                  via_pkg::REG_SR:   sr_in = req.write_data;
                  via_pkg::REG_T1CL, via_pkg::REG_T1LL:
                     t1_rel_in = {t1_rel_ff[16:9], req.write_data, 1'b0};
                  via_pkg::REG_T1LH: begin
                     t1_rel_in = {req.write_data, t1_rel_ff[8:1], 1'b0};
                     if (acr_ff[6]) flag_in = flag_in & ~via_pkg::F_T1[6:0];
                  end
                  via_pkg::REG_T1CH: begin
                     if (acr_ff[7:6] == 2'b10) out_b_in = out_b_ff & 8'h7f;
                     t1_rel_in = {req.write_data, t1_rel_ff[8:1], 1'b0};
                     t1_cnt_in = {2'b00, req.write_data, t1_rel_ff[8:1], 1'b1};
                     t1_done_in = 1'b0;
                     flag_in = flag_in & ~via_pkg::F_T1[6:0];
                  end
                  via_pkg::REG_T2CL:
                     t2_rel_in = {t2_rel_ff[16:9], req.write_data, 1'b0};
                  via_pkg::REG_T2CH: begin
                     t2_rel_in = {req.write_data, t2_rel_ff[8:1], 1'b0};
                     t2_cnt_in = {2'b00, req.write_data, t2_rel_ff[8:1], 1'b1};
                     flag_in = flag_in & ~via_pkg::F_T2[6:0];
                     t2_done_in = 1'b0;
                  end
                  via_pkg::REG_IER: begin
                     if (req.write_data[7]) ier_in = ier_ff | req.write_data[6:0];
                     else ier_in = ier_ff & ~req.write_data[6:0];
                  end
                  default: flag_in = flag_ff & ~req.write_data[6:0];
               endcase
            end
            via_pkg::MODE_CA1: begin
               if (lvl != ca1_ff) begin
                  if (pcr_ff[0] == lvl) begin
                     if (acr_ff[0]) latch_a_in = req.port_a_pins;
                     flag_in = flag_in | via_pkg::F_CA1[6:0];
                  end
                  ca1_in = lvl;
               end
            end
            via_pkg::MODE_CB1: begin
               if (lvl != cb1_ff) begin
                  if (pcr_ff[4] == lvl) begin
                     if (acr_ff[1]) latch_b_in = req.port_b_pins;
                     flag_in = flag_in | via_pkg::F_CB1[6:0];
                  end
                  cb1_in = lvl;
               end
            end
            via_pkg::MODE_CA2: begin
               if (lvl != ca2_ff && !pcr_ff[3]) begin
                  if (pcr_ff[2] == lvl) flag_in = flag_in | via_pkg::F_CA2[6:0];
                  ca2_in = lvl;
               end
            end
            via_pkg::MODE_CB2: begin
               if (lvl != cb2_ff && !pcr_ff[7]) begin
                  if (pcr_ff[6] == lvl) flag_in = flag_in | via_pkg::F_CB2[6:0];
                  cb2_in = lvl;
               end
            end
            default: ;
         endcase
      end
   end

   assign sts.need_wrap = $signed(t1_cnt_ff) < M3;

   assign rsp.read_data     = rd_ff;
   assign rsp.port_a_drive  = (out_a_ff & dir_a_ff) | ~dir_a_ff;
   assign rsp.port_a_strobe = sa_ff;
   assign rsp.port_b_drive  = (out_b_ff & dir_b_ff) | ~dir_b_ff;
   assign rsp.port_b_strobe = sb_ff;
   assign rsp.irq_level     = |(flag_ff & ier_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_a_ff <= 8'hff; out_b_ff <= 8'hff; dir_a_ff <= 8'hff; dir_b_ff <= 8'hff;
         latch_a_ff <= '0; latch_b_ff <= '0; sr_ff <= '0; acr_ff <= '0; pcr_ff <= '0;
         flag_ff <= '0; ier_ff <= '0;
         t1_rel_ff <= via_pkg::TIMER_RESET; t2_rel_ff <= via_pkg::TIMER_RESET;
         t1_cnt_ff <= 19'(via_pkg::TIMER_RESET); t2_cnt_ff <= 19'(via_pkg::TIMER_RESET);
         t1_done_ff <= 1'b1; t2_done_ff <= 1'b1; fired_ff <= '0;
         ca1_ff <= 1'b0; ca2_ff <= 1'b0; cb1_ff <= 1'b0; cb2_ff <= 1'b0;
         rd_ff <= '0; sa_ff <= 1'b0; sb_ff <= 1'b0;
      end else begin
         out_a_ff <= out_a_in; out_b_ff <= out_b_in; dir_a_ff <= dir_a_in; dir_b_ff <= dir_b_in;
         latch_a_ff <= latch_a_in; latch_b_ff <= latch_b_in; sr_ff <= sr_in;
         acr_ff <= acr_in; pcr_ff <= pcr_in; flag_ff <= flag_in; ier_ff <= ier_in;
         t1_rel_ff <= t1_rel_in; t2_rel_ff <= t2_rel_in;
         t1_cnt_ff <= t1_cnt_in; t2_cnt_ff <= t2_cnt_in;
         t1_done_ff <= t1_done_in; t2_done_ff <= t2_done_in; fired_ff <= fired_in;
         ca1_ff <= ca1_in; ca2_ff <= ca2_in; cb1_ff <= cb1_in; cb2_ff <= cb2_in;
         rd_ff <= rd_in; sa_ff <= sa_in; sb_ff <= sb_in;
      end
   end

   a_wrap_moves_up: assert property (@(posedge clock) disable iff (reset)
      cmd.wrap |=> $signed(t1_cnt_ff) > $signed($past(t1_cnt_ff)))
      else $error("timer-1 wrap did not raise count");
   a_strobe_is_write: assert property (@(posedge clock) disable iff (reset)
      cmd.load && req.mode != via_pkg::MODE_WRITE |=> !sa_ff && !sb_ff)
      else $error("strobe without write");
   a_fired_tick_only: assert property (@(posedge clock) disable iff (reset)
      cmd.load && req.mode != via_pkg::MODE_TICK |=> $stable(fired_ff))
      else $error("fired bits changed off tick");

endmodule

/* dv/via_checker.sv */
// Checker for the interface adapter: predicts each result and compares it.
`timescale 1ns / 100ps
module via_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  via_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  via_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   logic [7:0]  out_a, out_b, latch_a, latch_b, dir_a, dir_b, shift_reg;
   logic [7:0]  aux_ctrl, periph_ctrl, flag_reg;
   logic [6:0]  enable_reg;
   logic [16:0] t1_reload, t2_reload;
   int          t1_count, t2_count;
   bit          t1_done, t2_done;
   logic [1:0]  just_fired;
   bit          pin_ca1, pin_ca2, pin_cb1, pin_cb2;

   via_pkg::rsp_type expected_rsp[$];

   assign pending = expected_rsp.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic logic [7:0] count_byte(input int c, input int sh);
      logic [31:0] u;
      u = c + 1;
      return 8'((u >> sh) & 32'hff);
   endfunction

   function automatic void clear_b_side();
      flag_reg &= ~via_pkg::F_CB1;
      if ((periph_ctrl & 8'ha0) != 8'h20) flag_reg &= ~via_pkg::F_CB2;
   endfunction

   function automatic void clear_a_side();
      flag_reg &= ~via_pkg::F_CA1;
      if ((periph_ctrl & 8'h0a) != 8'h02) flag_reg &= ~via_pkg::F_CA2;
   endfunction

   function automatic void run_timers(input int cycles);
      int n1, n2, p, d;
      n1 = t1_count - cycles;
      just_fired = '0;
      if (n1 < -2 && t1_count > -3) begin
         if (!t1_done) begin
            flag_reg |= via_pkg::F_T1;
            if (n1 == -3) just_fired[0] = 1'b1;
            out_b ^= (aux_ctrl & 8'h80);
         end
         if (!aux_ctrl[6]) t1_done = 1'b1;
      end
      if (n1 < -3) begin
         p = int'(t1_reload) + 4;
         d = -3 - n1;
         n1 += ((d + p - 1) / p) * p;
      end
      t1_count = n1;
      if (!aux_ctrl[5]) begin
         n2 = t2_count - cycles;
         if (n2 < -2) begin
            if (!t2_done) begin
               flag_reg |= via_pkg::F_T2;
               if (n2 == -3) just_fired[1] = 1'b1;
               t2_done = 1'b1;
            end
            n2 += 32'h20000;
         end
         t2_count = n2;
      end
   endfunction

   function automatic logic [7:0] read_register(input logic [3:0] a,
                                                input logic [7:0] pa, pb);
      case (a)
         via_pkg::REG_ORA, via_pkg::REG_ORAN: begin
            if (a == via_pkg::REG_ORA) clear_a_side();
            return (out_a & dir_a) | ((aux_ctrl[0] ? latch_a : pa) & ~dir_a);
         end
         via_pkg::REG_ORB: begin
            clear_b_side();
            return (out_b & dir_b) | ((aux_ctrl[1] ? latch_b : pb) & ~dir_b);
         end
         via_pkg::REG_DDRA: return dir_a;
         via_pkg::REG_DDRB: return dir_b;
         via_pkg::REG_T1LL: return t1_reload[8:1];
         via_pkg::REG_T1LH: return t1_reload[16:9];
         via_pkg::REG_T1CL: begin
            if (!just_fired[0]) flag_reg &= ~via_pkg::F_T1;
            return count_byte(t1_count, 1);
         end
         via_pkg::REG_T1CH: return count_byte(t1_count, 9);
         via_pkg::REG_T2CL: begin
            if (!just_fired[1]) flag_reg &= ~via_pkg::F_T2;
            return count_byte(t2_count, 1);
         end
         via_pkg::REG_T2CH: return count_byte(t2_count, 9);
         via_pkg::REG_SR:   return shift_reg;
         via_pkg::REG_ACR:  return aux_ctrl;
         via_pkg::REG_PCR:  return periph_ctrl;
         via_pkg::REG_IER:  return {1'b1, enable_reg};
         default:           return flag_reg;
      endcase
   endfunction

   function automatic void write_register(input logic [3:0] a, input logic [7:0] v,
                                          output bit sa, output bit sb);
      sa = 1'b0;
      sb = 1'b0;
      case (a)
         via_pkg::REG_ORA, via_pkg::REG_ORAN: begin
            if (a == via_pkg::REG_ORA) clear_a_side();
            out_a = v;
            sa = 1'b1;
         end
         via_pkg::REG_ORB: begin
            clear_b_side();
            out_b = v;
            sb = 1'b1;
         end
         via_pkg::REG_DDRA: begin dir_a = v; sa = 1'b1; end
         via_pkg::REG_DDRB: begin dir_b = v; sb = 1'b1; end
         via_pkg::REG_ACR:  aux_ctrl = v;
         via_pkg::REG_PCR:  periph_ctrl = v;
         via_pkg::REG_SR:   shift_reg = v;
         via_pkg::REG_T1CL, via_pkg::REG_T1LL: t1_reload[8:1] = v;
         via_pkg::REG_T1LH: begin
            t1_reload[16:9] = v;
            if (aux_ctrl[6]) flag_reg &= ~via_pkg::F_T1;
         end
         via_pkg::REG_T1CH: begin
            if ((aux_ctrl & 8'hc0) == 8'h80) out_b &= 8'h7f;
            t1_reload[16:9] = v;
            t1_count = int'(t1_reload) + 1;
            t1_done = 1'b0;
            flag_reg &= ~via_pkg::F_T1;
         end
         via_pkg::REG_T2CL: t2_reload[8:1] = v;
         via_pkg::REG_T2CH: begin
            t2_reload[16:9] = v;
            t2_count = int'(t2_reload) + 1;
            flag_reg &= ~via_pkg::F_T2;
            t2_done = 1'b0;
         end
         via_pkg::REG_IER: begin
            if (v[7]) enable_reg |= v[6:0];
            else enable_reg &= ~v[6:0];
         end
         default: flag_reg &= ~(v & 8'h7f);
      endcase
   endfunction

   function automatic via_pkg::rsp_type predict_access(input via_pkg::req_type r);
      via_pkg::rsp_type o;
      bit               sa, sb;
      o = '0;
      sa = 1'b0;
      sb = 1'b0;
      case (r.mode)
         via_pkg::MODE_TICK:  run_timers(int'(r.elapsed));
         via_pkg::MODE_READ:
            o.read_data = read_register(r.reg_addr, r.port_a_pins, r.port_b_pins);
         via_pkg::MODE_WRITE: write_register(r.reg_addr, r.write_data, sa, sb);
         via_pkg::MODE_CA1: if (r.pin_level != pin_ca1) begin
            if (periph_ctrl[0] == r.pin_level) begin
               if (aux_ctrl[0]) latch_a = r.port_a_pins;
               flag_reg |= via_pkg::F_CA1;
            end
            pin_ca1 = r.pin_level;
         end
         via_pkg::MODE_CB1: if (r.pin_level != pin_cb1) begin
            if (periph_ctrl[4] == r.pin_level) begin
               if (aux_ctrl[1]) latch_b = r.port_b_pins;
               flag_reg |= via_pkg::F_CB1;
            end
            pin_cb1 = r.pin_level;
         end
         via_pkg::MODE_CA2: if (r.pin_level != pin_ca2 && !periph_ctrl[3]) begin
            if (periph_ctrl[2] == r.pin_level) flag_reg |= via_pkg::F_CA2;
            pin_ca2 = r.pin_level;
         end
         via_pkg::MODE_CB2: if (r.pin_level != pin_cb2 && !periph_ctrl[7]) begin
            if (periph_ctrl[6] == r.pin_level) flag_reg |= via_pkg::F_CB2;
            pin_cb2 = r.pin_level;
         end
         default: ;
      endcase
      flag_reg[7] = |(flag_reg[6:0] & enable_reg);
      o.port_a_drive  = (out_a & dir_a) | ~dir_a;
      o.port_b_drive  = (out_b & dir_b) | ~dir_b;
      o.port_a_strobe = sa;
      o.port_b_strobe = sb;
      o.irq_level     = flag_reg[7];
      return o;
   endfunction

   always @(posedge clock) begin
      via_pkg::rsp_type want;
      if (reset) begin
         out_a = 8'hff; out_b = 8'hff; dir_a = 8'hff; dir_b = 8'hff;
         latch_a = '0; latch_b = '0; shift_reg = '0;
         aux_ctrl = '0; periph_ctrl = '0; flag_reg = '0; enable_reg = '0;
         t1_reload = via_pkg::TIMER_RESET; t2_reload = via_pkg::TIMER_RESET;
         t1_count = int'(via_pkg::TIMER_RESET); t2_count = int'(via_pkg::TIMER_RESET);
         t1_done = 1'b1; t2_done = 1'b1; just_fired = '0;
         pin_ca1 = 1'b0; pin_ca2 = 1'b0; pin_cb1 = 1'b0; pin_cb2 = 1'b0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected item", int'(rsp_data), 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report("read_data", int'(rsp_data.read_data), int'(want.read_data));
               if (rsp_data.port_a_drive !== want.port_a_drive)
                  report("port_a_drive", int'(rsp_data.port_a_drive),
                         int'(want.port_a_drive));
               if (rsp_data.port_a_strobe !== want.port_a_strobe)
                  report("port_a_strobe", int'(rsp_data.port_a_strobe),
                         int'(want.port_a_strobe));
               if (rsp_data.port_b_drive !== want.port_b_drive)
                  report("port_b_drive", int'(rsp_data.port_b_drive),
                         int'(want.port_b_drive));
               if (rsp_data.port_b_strobe !== want.port_b_strobe)
                  report("port_b_strobe", int'(rsp_data.port_b_strobe),
                         int'(want.port_b_strobe));
               if (rsp_data.irq_level !== want.irq_level)
                  report("irq_level", int'(rsp_data.irq_level), int'(want.irq_level));
            end
         end
         // state is updated with blocking writes inside the predictor
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_access(req_data));
      end
   end

endmodule

/* dv/versatile_interface_adapter_tb.sv */
// Stimulus and verdict for the versatile interface adapter.
`timescale 1ns / 100ps
module versatile_interface_adapter_tb;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   via_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   via_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   bit               hold_rsp = 0;
   bit               stim_done = 0;

   always #1 clock = ~clock;

   versatile_interface_adapter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   via_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic via_pkg::req_type random_item(input bit ordered);
      via_pkg::req_type r;
      int               pick;
      r.mode        = 3'($urandom_range(0, 7));
      r.reg_addr    = 4'($urandom_range(0, 15));
      r.write_data  = 8'($urandom);
      r.elapsed     = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
      r.pin_level   = 1'($urandom);
      r.port_a_pins = 8'($urandom);
      r.port_b_pins = 8'($urandom);
      if (ordered) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) r.mode = via_pkg::MODE_TICK;
         else if (pick < 5) r.mode = via_pkg::MODE_READ;
         else if (pick < 8) r.mode = via_pkg::MODE_WRITE;
         else r.mode = 3'($urandom_range(via_pkg::MODE_CA1, via_pkg::MODE_CB2));
         // short timer periods so timers fire often
         if (r.mode == via_pkg::MODE_WRITE && $urandom_range(0, 2) != 0 &&
             (r.reg_addr == via_pkg::REG_T1CH || r.reg_addr == via_pkg::REG_T2CH ||
              r.reg_addr == via_pkg::REG_T1LH))
            r.write_data = 8'($urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic send(input via_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_op(input logic [2:0] m, input logic [3:0] a,
                          input logic [7:0] d);
      via_pkg::req_type r;
      r = random_item(1'b0);
      r.mode = m;
      r.reg_addr = a;
      r.write_data = d;
      send(r);
   endtask

   task automatic go_idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // receiver: random stalls, long stretches without, one long hold-off
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = $urandom_range(0, 3);
         rsp_ready <= (stall != 0 || stim_done);
      end
   end

   initial begin
      via_pkg::req_type r;
      int               burst, waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every register, pins, extremes
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_IER, 8'hff);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_DDRA, 8'h0f);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_DDRB, 8'h00);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_ORA, 8'ha5);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_ORB, 8'h5a);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_ORAN, 8'hff);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_ACR, 8'hc3);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_PCR, 8'h11);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_SR, 8'h3c);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_T1LL, 8'h02);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_T1CH, 8'h00);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_T2CL, 8'h01);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_T2CH, 8'h00);
      send_op(via_pkg::MODE_TICK, via_pkg::REG_ORB, 8'h00);
      for (int i = 0; i < 16; i++) send_op(via_pkg::MODE_READ, i[3:0], 8'h00);
      for (int m = via_pkg::MODE_CA1; m <= 7; m++) begin
         r = random_item(1'b0);
         r.mode = 3'(m);
         r.pin_level = 1'b1;
         send(r);
         r.pin_level = 1'b0;
         send(r);
      end
      r = random_item(1'b0);
      r.mode = via_pkg::MODE_TICK;
      r.elapsed = 7'd0;
      send(r);
      r.elapsed = 7'h7f;
      send(r);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_T1LH, 8'hff);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_IFR, 8'h7f);
      send_op(via_pkg::MODE_WRITE, via_pkg::REG_IER, 8'h7f);

      // random bursts with gaps
      for (int n = 0; n < 500; ) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++, n++) begin
            if (n == 150) hold_rsp = 1'b1;
            send(random_item($urandom_range(0, 9) != 0));
         end
         if (n > 300 && n < 330) begin
            // pause until the block has drained
            req_valid <= 1'b0;
            waited = 0;
            while (pending != 0 && waited < 10000) begin
               @(posedge clock);
               waited++;
            end
         end else if ($urandom_range(0, 2) != 0) begin
            go_idle($urandom_range(1, 12));
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;

      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS versatile_interface_adapter");
      end else begin
         $display("FAIL versatile_interface_adapter");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("FAIL versatile_interface_adapter");
      $finish;
   end

endmodule

/* versatile_interface_adapter.f */
hw/rtl/via_pkg.sv
hw/rtl/via_ctrl.sv
hw/rtl/via_dp.sv
hw/rtl/versatile_interface_adapter.sv
dv/via_checker.sv
dv/versatile_interface_adapter_tb.sv
